// ===== sv/stereo_linear_resampler_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stereo linear resampler.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_DEFINES_SVH
`define STEREO_LINEAR_RESAMPLER_DEFINES_SVH

// The property must hold in every cycle outside of reset.
`define SRL_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRL_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/srl_pkg.sv =====
// ---------------------------------------------------------------------------
// srl_pkg
// Widths, constants and shared types of the stereo linear resampler.
// ---------------------------------------------------------------------------
package srl_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int PHASE_FRAC_W = 28;
  localparam int PHASE_W      = 33;
  localparam int STEP_W       = 32;
  localparam int DATA_W       = 2 * SAMPLE_W;
  localparam int MAX_OUTPUTS  = 16;
  localparam int CNT_W        = $clog2(MAX_OUTPUTS + 1);
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << PHASE_FRAC_W;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1) << PHASE_FRAC_W;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BYPASS     = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Operands handed to one interpolation lane.
  typedef struct packed {
    sample_t                 a;
    sample_t                 b;
    logic [PHASE_FRAC_W-1:0] frac;
  } lane_in_t;

  // Control that travels alongside the lane operands.
  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

endpackage

// ===== sv/srl_lane.sv =====
// ---------------------------------------------------------------------------
// srl_lane
// One channel of interpolation: a + floor((b - a) * frac / 2^28).
// ---------------------------------------------------------------------------
module srl_lane import srl_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  lane_in_t op,
  output sample_t  res
);

  logic signed [SAMPLE_W:0]                  diff;
  logic signed [PHASE_FRAC_W:0]              frac_s;
  logic signed [SAMPLE_W+PHASE_FRAC_W+1:0]   prod;
  logic signed [SAMPLE_W+PHASE_FRAC_W+1:0]   prod_r;
  sample_t                                   a_r;
  logic signed [SAMPLE_W+PHASE_FRAC_W+1:0]   shifted;
  logic signed [SAMPLE_W:0]                  q;
  logic signed [SAMPLE_W:0]                  sum;

  assign diff   = {op.b[SAMPLE_W-1], op.b} - {op.a[SAMPLE_W-1], op.a};
  assign frac_s = {1'b0, op.frac};
  assign prod   = diff * frac_s;

  // Product register; the add happens in the next stage.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
      a_r    <= op.a;
    end
  end

  // Arithmetic shift floors the quotient, matching round toward negative.
  assign shifted = prod_r >>> PHASE_FRAC_W;
  assign q       = shifted[SAMPLE_W:0];
  assign sum     = {a_r[SAMPLE_W-1], a_r} + q;
  assign res     = sum[SAMPLE_W-1:0];

endmodule

// ===== sv/srl_merge.sv =====
// ---------------------------------------------------------------------------
// srl_merge
// Joins the two lane results into one output item and holds it until taken.
// ---------------------------------------------------------------------------
module srl_merge import srl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  issue_t            issue,
  input  sample_t           left_res,
  input  sample_t           right_res,
  output logic              advance,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  issue_t            s1_r;
  logic              out_valid_r;
  logic              out_last_r;
  logic [DATA_W-1:0] out_data_r;

  // The whole pipeline moves whenever the output register is free.
  assign advance = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_r        <= issue;
      out_valid_r <= s1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_last_r <= s1_r.last;
      out_data_r <= {right_res, left_res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/stereo_linear_resampler.sv =====
// Each result passes the lane product register and then the output register; a stall
// at the output holds both. The phase sequencer issues one interpolation per cycle to
// both lanes unless the output stalls, and takes no new item until the current one ends.
// Reset is synchronous: phase_step 1.0, bypass off, previous frame zero, read
// position 1.0, so the first frame after reset only primes the previous frame.
// ---------------------------------------------------------------------------
// stereo_linear_resampler
// Linear interpolation sample rate converter for stereo Q1.23 frames.
// ---------------------------------------------------------------------------
`include "stereo_linear_resampler_defines.svh"

module stereo_linear_resampler import srl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input frames.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [23:0] left_in, [47:24] right_in
  // Output frames.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [23:0] left_out, [47:24] right_out
  output logic                  out_tlast
);

  // Configuration registers.
  logic [STEP_W-1:0]  step_r;
  logic               bypass_r;

  // Sequencer state. One item is worked on at a time: busy_r is set while
  // the current frame still has interpolations to issue.
  logic               busy_r,      busy_nxt;
  logic               byp_item_r;
  logic [CNT_W-1:0]   cnt_r,       cnt_nxt;
  logic [PHASE_W-1:0] phase_r,     phase_nxt;
  sample_t            prev_l_r,    prev_l_nxt;
  sample_t            prev_r_r,    prev_r_nxt;
  sample_t            cur_l_r;
  sample_t            cur_r_r;

  logic               in_accept;
  logic               advance;
  logic               phase_lt_one;
  logic [PHASE_W-1:0] phase_add;
  logic               cap_hit;

  issue_t             issue;
  lane_in_t           lane_l_in;
  lane_in_t           lane_r_in;
  sample_t            left_res;
  sample_t            right_res;

  assign in_tready = !busy_r;
  assign in_accept = in_tvalid && in_tready;

  // Configuration writes must arrive only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      bypass_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PHASE_STEP: step_r   <= cfg_wdata[STEP_W-1:0];
        REG_BYPASS:     bypass_r <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  assign phase_lt_one = phase_r < PHASE_ONE;
  assign phase_add    = phase_r + {1'b0, step_r};
  assign cap_hit      = cnt_r == CNT_W'(MAX_OUTPUTS - 1);

  // Next-state logic of the sequencer. In bypass the frame is sent through
  // the lanes with both ends equal and a zero fraction, which reproduces it.
  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    prev_l_nxt = prev_l_r;
    prev_r_nxt = prev_r_r;
    issue      = '0;
    lane_l_in  = '{a: prev_l_r, b: cur_l_r, frac: phase_r[PHASE_FRAC_W-1:0]};
    lane_r_in  = '{a: prev_r_r, b: cur_r_r, frac: phase_r[PHASE_FRAC_W-1:0]};

    if (busy_r) begin
      priority if (byp_item_r) begin
        lane_l_in = '{a: cur_l_r, b: cur_l_r, frac: '0};
        lane_r_in = '{a: cur_r_r, b: cur_r_r, frac: '0};
        if (advance) begin
          issue      = '{valid: 1'b1, last: 1'b1};
          prev_l_nxt = cur_l_r;
          prev_r_nxt = cur_r_r;
          busy_nxt   = 1'b0;
        end
      end else if (phase_lt_one) begin
        if (advance) begin
          issue.valid = 1'b1;
          issue.last  = cap_hit || !(phase_add < PHASE_ONE);
          if (issue.last) begin
            // The interval ends: step into the next one, or drop the rest
            // of it when the output cap cut it short.
            phase_nxt  = (phase_add < PHASE_ONE) ? '0 : phase_add - PHASE_ONE;
            prev_l_nxt = cur_l_r;
            prev_r_nxt = cur_r_r;
            cnt_nxt    = '0;
            busy_nxt   = 1'b0;
          end else begin
            phase_nxt = phase_add;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
      end else begin
        // A large step left nothing to emit in this interval.
        phase_nxt  = phase_r - PHASE_ONE;
        prev_l_nxt = cur_l_r;
        prev_r_nxt = cur_r_r;
        busy_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      phase_r  <= PHASE_ONE;
      prev_l_r <= '0;
      prev_r_r <= '0;
    end else begin
      busy_r   <= busy_nxt || in_accept;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      prev_l_r <= prev_l_nxt;
      prev_r_r <= prev_r_nxt;
    end
  end

  // Frame capture; payload only, so no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_l_r    <= in_tdata[SAMPLE_W-1:0];
      cur_r_r    <= in_tdata[DATA_W-1:SAMPLE_W];
      byp_item_r <= bypass_r;
    end
  end

  // Two identical lanes, one per channel.
  srl_lane u_lane_left (
    .clk (clk),
    .en  (advance),
    .op  (lane_l_in),
    .res (left_res)
  );

  srl_lane u_lane_right (
    .clk (clk),
    .en  (advance),
    .op  (lane_r_in),
    .res (right_res)
  );

  // The merge stage packs both channels into one output item.
  srl_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .left_res   (left_res),
    .right_res  (right_res),
    .advance    (advance),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // An accepted frame always leaves work for the sequencer.
  `SRL_CHECK_NEXT(a_accept_busy, in_accept, busy_r, "accepted item did not start the sequencer")
  // The result counter is cleared whenever the sequencer is idle.
  `SRL_CHECK(a_idle_cnt, !busy_r |-> cnt_r == '0, "result counter not cleared when idle")
  // The final result of an item releases the sequencer.
  `SRL_CHECK_NEXT(a_last_done, issue.valid && issue.last, !busy_r, "sequencer busy after last result")
  // No item yields more results than the cap.
  `SRL_CHECK(a_cnt_cap, cnt_r < CNT_W'(MAX_OUTPUTS), "result count beyond cap")

endmodule
